FILE: rtl/flowgram_extreme_call_filter_top_assert.svh
// Assertion helpers for the extreme-call filter.
// Each macro samples at the rising edge of clk and is off while rst_n is low.
`ifndef FLOWGRAM_EXTREME_CALL_FILTER_TOP_ASSERT_SVH
`define FLOWGRAM_EXTREME_CALL_FILTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FECF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fecf: same-cycle check failed");

// Next-cycle implication.
`define FECF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fecf: next-cycle check failed");

`endif

FILE: rtl/fecf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fecf_pkg;

  // Read length limit and derived counter widths
  localparam int MAX_FLOWS = 1024;
  localparam int CNT_W     = $clog2(MAX_FLOWS + 1);
  localparam int SUM_W     = CNT_W + 1;

  // Field widths
  localparam int LEN_W    = 7;
  localparam int SIG_W    = 16;
  localparam int RATIO_W  = 16;
  localparam int CLIP_W   = 16;
  localparam int BASE_W   = 17;
  localparam int CFG_D_W  = 16;
  localparam int TRIM_P_W = CNT_W + RATIO_W;
  localparam int REJ_P_W  = SUM_W + RATIO_W;

  // Signal windows for a good call
  localparam logic [SIG_W-1:0] ONE_LOW_LIMIT  = SIG_W'(59);
  localparam logic [SIG_W-1:0] ONE_HIGH_LIMIT = SIG_W'(140);
  localparam logic [SIG_W-1:0] TWO_LOW_LIMIT  = SIG_W'(159);
  localparam logic [SIG_W-1:0] TWO_HIGH_LIMIT = SIG_W'(240);

  localparam logic [BASE_W-1:0] BASES_MAX = {BASE_W{1'b1}};
  localparam logic [CLIP_W-1:0] CLIP_MAX  = {CLIP_W{1'b1}};

  // Register reset values
  localparam logic                 RST_FILTER_ENABLE = 1'b1;
  localparam logic [RATIO_W-1:0]   RST_REJECT_RATIO  = RATIO_W'(1966);
  localparam logic [RATIO_W-1:0]   RST_TRIM_SHARE    = RATIO_W'(1966);
  localparam logic [CLIP_W-1:0]    RST_MIN_KEEP      = CLIP_W'(8);

  // Configuration register index
  typedef enum logic [1:0] {
    CFG_FILTER_ENABLE = 2'd0,
    CFG_REJECT_RATIO  = 2'd1,
    CFG_TRIM_SHARE    = 2'd2,
    CFG_MIN_KEEP      = 2'd3
  } cfg_idx_t;

  // One flow of a read
  typedef struct packed {
    logic [LEN_W-1:0] call_length;
    logic [SIG_W-1:0] flow_signal;
    logic             read_class;
    logic             last_flow;
  } flow_t;

  // Per-read verdict
  typedef struct packed {
    logic              reject_read;
    logic              clip_valid;
    logic [CLIP_W-1:0] clip_right;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/fecf_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow request channel
interface fecf_in_if;
  logic                          valid;
  logic                          ready;
  logic [fecf_pkg::LEN_W-1:0]    call_length;
  logic [fecf_pkg::SIG_W-1:0]    flow_signal;
  logic                          read_class;
  logic                          last_flow;

  modport source (output valid, call_length, flow_signal, read_class, last_flow,
                  input ready);
  modport sink   (input valid, call_length, flow_signal, read_class, last_flow,
                  output ready);
endinterface

// Verdict channel
interface fecf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          reject_read;
  logic                          clip_valid;
  logic [fecf_pkg::CLIP_W-1:0]   clip_right;

  modport source (output valid, reject_read, clip_valid, clip_right, input ready);
  modport sink   (input valid, reject_read, clip_valid, clip_right, output ready);
endinterface

// Register write channel
interface fecf_cfg_if;
  logic                          valid;
  logic                          ready;
  fecf_pkg::cfg_idx_t            index;
  logic [fecf_pkg::CFG_D_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/flowgram_extreme_call_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Extreme-call filter and trimmer: takes one flow per cycle, sustained while no
// last flow waits on a held verdict, and returns one verdict per read on its
// last flow. A flow lands in an input register; from there it is folded into
// the per-read counters, and a last flow also loads the output register. The
// per-flow path is an 11x16 multiply-compare for the trim test (with the 12x16
// reject compare beside it); the trim point of each flow feeds the next, which
// fixes the rate at one flow per cycle. The input stays open while a verdict
// waits, until a second last flow would overwrite it. No clearing pass after
// reset; the config port is always ready, and the user must write it only
// while the block is idle: the block itself does not enforce this.
module flowgram_extreme_call_filter_top (
  input  wire              clk,
  input  wire              rst_n,
  fecf_in_if.sink          in_if,
  fecf_out_if.source       out_if,
  fecf_cfg_if.sink         cfg_if
);

  localparam int CNT_W  = fecf_pkg::CNT_W;
  localparam int SUM_W  = fecf_pkg::SUM_W;
  localparam int BASE_W = fecf_pkg::BASE_W;

  // Configuration registers
  logic                            filter_enable_r;
  logic [fecf_pkg::RATIO_W-1:0]    reject_ratio_r;
  logic [fecf_pkg::RATIO_W-1:0]    trim_share_r;
  logic [fecf_pkg::CLIP_W-1:0]     min_keep_r;

  // Input stage
  fecf_pkg::flow_t                 flow_r;
  logic                            in_v_r;
  logic                            in_v_nxt;
  logic                            in_acc;

  // Per-read state
  logic [CNT_W-1:0]                onemer_r,  onemer_nxt;
  logic [CNT_W-1:0]                twomer_r,  twomer_nxt;
  logic [CNT_W-1:0]                ext1_r,    ext1_nxt;
  logic [CNT_W-1:0]                ext2_r,    ext2_nxt;
  logic [CNT_W-1:0]                flow_idx_r, flow_idx_nxt;
  logic [BASE_W-1:0]               bases_r,   bases_nxt;
  logic [BASE_W-1:0]               trim_r,    trim_nxt;

  // Output stage
  fecf_pkg::result_t               result_r, result_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Datapath
  logic                            out_free;
  logic                            proc;
  logic                            take;
  logic                            is_one, is_two, one_ext, two_ext;
  logic [CNT_W-1:0]                onemer_a, twomer_a, ext1_a, ext2_a;
  logic [BASE_W:0]                 bases_sum;
  logic [BASE_W-1:0]               bases_a, trim_a;
  logic [fecf_pkg::TRIM_P_W-1:0]   trim_lhs, trim_rhs;
  logic [SUM_W-1:0]                ext_sum, tot_sum;
  logic [fecf_pkg::REJ_P_W-1:0]    rej_lhs, rej_rhs;
  logic                            fail, keep;

  // Handshakes
  assign out_free     = !out_valid_r || out_if.ready;
  assign proc         = in_v_r && (!flow_r.last_flow || out_free);
  assign in_if.ready  = !in_v_r || proc;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  // Classify the held flow
  assign take    = flow_idx_r < CNT_W'(fecf_pkg::MAX_FLOWS);
  assign is_one  = flow_r.call_length == fecf_pkg::LEN_W'(1);
  assign is_two  = flow_r.call_length == fecf_pkg::LEN_W'(2);
  assign one_ext = (flow_r.flow_signal <= fecf_pkg::ONE_LOW_LIMIT) ||
                   (flow_r.flow_signal >= fecf_pkg::ONE_HIGH_LIMIT);
  assign two_ext = (flow_r.flow_signal <= fecf_pkg::TWO_LOW_LIMIT) ||
                   (flow_r.flow_signal >= fecf_pkg::TWO_HIGH_LIMIT);

  // Accumulate counts and saturating base total
  assign onemer_a  = onemer_r + CNT_W'(take && is_one);
  assign twomer_a  = twomer_r + CNT_W'(take && is_two);
  assign ext1_a    = ext1_r + CNT_W'(take && is_one && one_ext);
  assign ext2_a    = ext2_r + CNT_W'(take && is_two && two_ext);
  assign bases_sum = {1'b0, bases_r} + (BASE_W + 1)'(flow_r.call_length);
  assign bases_a   = !take ? bases_r :
                     (bases_sum[BASE_W] ? fecf_pkg::BASES_MAX : bases_sum[BASE_W-1:0]);

  // Trim test: extreme one-mer share within the trim ratio
  assign trim_lhs = {ext1_a, {fecf_pkg::RATIO_W{1'b0}}};
  assign trim_rhs = fecf_pkg::TRIM_P_W'(onemer_a) * fecf_pkg::TRIM_P_W'(trim_share_r);
  assign trim_a   = (take && (trim_lhs <= trim_rhs)) ? bases_a : trim_r;

  // Reject test on the totals after this flow
  assign ext_sum = SUM_W'(ext1_a) + SUM_W'(ext2_a);
  assign tot_sum = SUM_W'(onemer_a) + SUM_W'(twomer_a);
  assign rej_lhs = {ext_sum, {fecf_pkg::RATIO_W{1'b0}}};
  assign rej_rhs = fecf_pkg::REJ_P_W'(tot_sum) * fecf_pkg::REJ_P_W'(reject_ratio_r);
  assign fail    = filter_enable_r && !flow_r.read_class && (rej_lhs > rej_rhs);
  assign keep    = trim_a > {1'b0, min_keep_r};

  // Next state of the per-read counters
  always_comb begin
    onemer_nxt   = onemer_r;
    twomer_nxt   = twomer_r;
    ext1_nxt     = ext1_r;
    ext2_nxt     = ext2_r;
    bases_nxt    = bases_r;
    trim_nxt     = trim_r;
    flow_idx_nxt = flow_idx_r;
    if (proc) begin
      if (flow_r.last_flow) begin
        onemer_nxt   = '0;
        twomer_nxt   = '0;
        ext1_nxt     = '0;
        ext2_nxt     = '0;
        bases_nxt    = '0;
        trim_nxt     = '0;
        flow_idx_nxt = '0;
      end else begin
        onemer_nxt   = onemer_a;
        twomer_nxt   = twomer_a;
        ext1_nxt     = ext1_a;
        ext2_nxt     = ext2_a;
        bases_nxt    = bases_a;
        trim_nxt     = trim_a;
        flow_idx_nxt = flow_idx_r + CNT_W'(take);
      end
    end
  end

  // Next verdict and output valid
  always_comb begin
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r;
    if (proc && flow_r.last_flow) begin
      out_valid_nxt          = 1'b1;
      result_nxt.reject_read = fail && !keep;
      result_nxt.clip_valid  = fail && keep;
      result_nxt.clip_right  = '0;
      if (fail && keep) begin
        result_nxt.clip_right = trim_a[BASE_W-1] ? fecf_pkg::CLIP_MAX
                                                 : trim_a[fecf_pkg::CLIP_W-1:0];
      end
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the input flow until processed
  assign in_v_nxt = in_acc ? 1'b1 : (proc ? 1'b0 : in_v_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      onemer_r    <= '0;
      twomer_r    <= '0;
      ext1_r      <= '0;
      ext2_r      <= '0;
      bases_r     <= '0;
      trim_r      <= '0;
      flow_idx_r  <= '0;
    end else begin
      in_v_r      <= in_v_nxt;
      out_valid_r <= out_valid_nxt;
      onemer_r    <= onemer_nxt;
      twomer_r    <= twomer_nxt;
      ext1_r      <= ext1_nxt;
      ext2_r      <= ext2_nxt;
      bases_r     <= bases_nxt;
      trim_r      <= trim_nxt;
      flow_idx_r  <= flow_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flow_r.call_length <= in_if.call_length;
      flow_r.flow_signal <= in_if.flow_signal;
      flow_r.read_class  <= in_if.read_class;
      flow_r.last_flow   <= in_if.last_flow;
    end
    result_r <= result_nxt;
  end

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r <= fecf_pkg::RST_FILTER_ENABLE;
      reject_ratio_r  <= fecf_pkg::RST_REJECT_RATIO;
      trim_share_r    <= fecf_pkg::RST_TRIM_SHARE;
      min_keep_r      <= fecf_pkg::RST_MIN_KEEP;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        fecf_pkg::CFG_FILTER_ENABLE: filter_enable_r <= cfg_if.data[0];
        fecf_pkg::CFG_REJECT_RATIO:  reject_ratio_r  <= cfg_if.data;
        fecf_pkg::CFG_TRIM_SHARE:    trim_share_r    <= cfg_if.data;
        fecf_pkg::CFG_MIN_KEEP:      min_keep_r      <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Drive the verdict channel
  assign out_if.valid       = out_valid_r;
  assign out_if.reject_read = result_r.reject_read;
  assign out_if.clip_valid  = result_r.clip_valid;
  assign out_if.clip_right  = result_r.clip_right;

  // Checks
  `include "flowgram_extreme_call_filter_top_assert.svh"

  `FECF_ASSERT_NEXT(a_verdict_loaded, proc && flow_r.last_flow, out_valid_r)
  `FECF_ASSERT_IMP(a_verdict_exclusive, out_valid_r, !(result_r.reject_read && result_r.clip_valid))
  `FECF_ASSERT_IMP(a_counts_bounded, 1'b1, (SUM_W'(onemer_r) + SUM_W'(twomer_r)) <= SUM_W'(flow_idx_r))
  `FECF_ASSERT_IMP(a_index_bounded, 1'b1, flow_idx_r <= CNT_W'(fecf_pkg::MAX_FLOWS))

endmodule

`default_nettype wire
